// File: rtl/scts_pkg.sv
// Shared types and constants for the sorted coordinate table store.
package scts_pkg;

   localparam int COORD_W = 16;
   localparam int VALUE_W = 64;
   localparam int REG_W   = 17;
   localparam int TOTAL_W = 11;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OOB  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   localparam logic [REG_W-1:0] DIM_RESET = 17'h10000;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] row_index;
      logic [COORD_W-1:0] col_index;
      logic [VALUE_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               hit;
      logic [STAT_W-1:0]  status;
      logic [TOTAL_W-1:0] entry_total;
   } rsp_type;

endpackage

// File: rtl/scts_table_ram.sv
// Entry table memory: one write port and one read port with registered read data.
module scts_table_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sorted_coordinate_table_store.sv
// Top level of the sorted coordinate table store: sequencer, search and shift control.
//
// This block holds a sparse matrix as a table of (row, column, value) entries kept in
// ascending order of row, then column, in a single-port-read, single-port-write memory
// of CAPACITY entries. Each request word is handled to completion before the next one is
// taken; req_stall is high for the whole time. A lookup is a binary search in which one
// key comparator is reused each step. Each probe takes a read step (S_PROBE) and a compare
// step (S_CMP) because the memory read data is registered. A table of n entries needs at
// most ceil(log2(n+1)) probes, and a search that misses ends with a probe step that finds
// the window empty. A read or a replacing write then passes to S_DONE, which raises
// rsp_valid once the output register is free. A write of a new coordinate moves every
// later entry up one place through the memory, one entry per cycle, and then stores the
// new entry. A read outside the configured matrix size goes straight to S_DONE and is
// answered with an out-of-bounds status. A new coordinate written to a full table is
// refused with a full status. The memory holds no reset state; only entries below the
// entry count are ever read. The register port is always ready and is meant to be written
// while the block is idle. The response word sits in an output register, so a new request
// is taken while an earlier response waits.
module sorted_coordinate_table_store #(
   parameter int CAPACITY   = 1024,
   parameter int INDEX_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  scts_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output scts_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scts_pkg::REG_W-1:0]          csr_wdata
);

   // Stored coordinate width: coordinates are kept modulo 2^KW, KW being the smaller of INDEX_BITS and COORD_W.
   localparam int KW    = (INDEX_BITS < scts_pkg::COORD_W) ? INDEX_BITS : scts_pkg::COORD_W;
   localparam int ENT_W = 2 * KW + scts_pkg::VALUE_W;
   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PROBE  = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_INSERT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [scts_pkg::REG_W-1:0] num_rows_ff, num_cols_ff;

   // Request being worked on.
   logic op_ff, op_in;
   logic [KW-1:0] row_ff, row_in;
   logic [KW-1:0] col_ff, col_in;
   logic [scts_pkg::VALUE_W-1:0] wval_ff, wval_in;

   // Search window, probe and insert position.
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] pos_ff, pos_in;

   // Shift pipeline: sh_k is the next destination whose source still has to be read.
   logic [CW-1:0] sh_k_ff, sh_k_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pend_dst_ff, pend_dst_in;

   // Result under construction.
   logic hit_ff, hit_in;
   logic [scts_pkg::VALUE_W-1:0] rval_ff, rval_in;
   logic [scts_pkg::STAT_W-1:0] status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   scts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Memory port signals.
   logic ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [ENT_W-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [ENT_W-1:0] ram_rd_data;

   logic [CW-1:0] mid_calc;
   logic [2*KW-1:0] probe_key;
   logic [2*KW-1:0] own_key;
   logic [scts_pkg::VALUE_W-1:0] probe_val;
   logic [KW-1:0] req_row;
   logic [KW-1:0] req_col;
   logic req_oob;
   logic [CW+scts_pkg::TOTAL_W-1:0] total_wide;

   scts_table_ram #(
      .DEPTH  (CAPACITY),
      .DATA_W (ENT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_row  = req_data.row_index[KW-1:0];
   assign req_col  = req_data.col_index[KW-1:0];
   // A read is in bounds only when both coordinates fall below the configured size.
   assign req_oob  = (scts_pkg::REG_W'(req_row) >= num_rows_ff) ||
                     (scts_pkg::REG_W'(req_col) >= num_cols_ff);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign probe_key = ram_rd_data[ENT_W-1 -: 2*KW];
   assign probe_val = ram_rd_data[scts_pkg::VALUE_W-1:0];
   assign own_key   = {row_ff, col_ff};
   assign total_wide = {{scts_pkg::TOTAL_W{1'b0}}, count_ff};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      wval_in     = wval_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      pos_in      = pos_ff;
      sh_k_in     = sh_k_ff;
      pend_in     = pend_ff;
      pend_dst_in = pend_dst_ff;
      hit_in      = hit_ff;
      rval_in     = rval_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      // The waiting response word leaves once the receiver stops stalling.
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.operation;
               row_in    = req_row;
               col_in    = req_col;
               wval_in   = req_data.write_value;
               lo_in     = '0;
               hi_in     = count_ff;
               hit_in    = 1'b0;
               rval_in   = '0;
               status_in = scts_pkg::STAT_OK;
               if ((req_data.operation == scts_pkg::OP_READ) && req_oob) begin
                  status_in = scts_pkg::STAT_OOB;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = mid_calc[AW-1:0];
               mid_in      = mid_calc;
               state_in    = S_CMP;
            end else begin
               // Coordinate is absent; lo is where it belongs.
               pos_in = lo_ff;
               if (op_ff == scts_pkg::OP_READ) begin
                  state_in = S_DONE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_in = scts_pkg::STAT_FULL;
                  state_in  = S_DONE;
               end else begin
                  sh_k_in  = count_ff;
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_CMP: begin
            if (probe_key == own_key) begin
               hit_in = 1'b1;
               if (op_ff == scts_pkg::OP_READ) begin
                  rval_in = probe_val;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = mid_ff[AW-1:0];
                  ram_wr_data = {own_key, wval_ff};
               end
               state_in = S_DONE;
            end else if (probe_key < own_key) begin
               lo_in    = mid_ff + CW'(1);
               state_in = S_PROBE;
            end else begin
               hi_in    = mid_ff;
               state_in = S_PROBE;
            end
         end
         S_SHIFT: begin
            // Entry read last cycle lands one place higher this cycle.
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (sh_k_ff > pos_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = sh_k_ff[AW-1:0] - AW'(1);
               pend_in     = 1'b1;
               pend_dst_in = sh_k_ff[AW-1:0];
               sh_k_in     = sh_k_ff - CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_INSERT;
               end
            end
         end
         S_INSERT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = {own_key, wval_ff};
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.read_value  = rval_ff;
               rsp_data_in.hit         = hit_ff;
               rsp_data_in.status      = status_ff;
               rsp_data_in.entry_total = total_wide[scts_pkg::TOTAL_W-1:0];
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_rows_ff  <= scts_pkg::DIM_RESET;
         num_cols_ff  <= scts_pkg::DIM_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               scts_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
               scts_pkg::CSR_NUM_COLS: num_cols_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      wval_ff     <= wval_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pos_ff      <= pos_in;
      sh_k_ff     <= sh_k_in;
      pend_dst_ff <= pend_dst_in;
      hit_ff      <= hit_in;
      rval_ff     <= rval_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // The table never holds more entries than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Every insert grows the table by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the entry count by one");

   // The search window stays inside the stored entries.
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> ((lo_ff <= hi_ff) && (hi_ff <= count_ff)))
      else $error("search window out of range");

   // A refused insert is only reported when the table is really full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (status_ff == scts_pkg::STAT_FULL)) |->
      (count_ff == CW'(CAPACITY)))
      else $error("full status with room left in the table");

   // A new response word only appears when the sequencer finishes an item.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the finish step");

endmodule
